// ===== rtl/two_beam_direction_counter_top_macros.svh =====
// Assertion macros for the two-beam direction counter.
`ifndef TWO_BEAM_DIRECTION_COUNTER_TOP_MACROS_SVH
`define TWO_BEAM_DIRECTION_COUNTER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define TBDC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tbdc same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define TBDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tbdc next-cycle check failed");

`endif

// ===== rtl/tbdc_pkg.sv =====
// Types and constants for the two-beam direction counter.
`timescale 1ns / 1ps
`default_nettype none

package tbdc_pkg;

  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;

  typedef logic [CFG_W-1:0] cfg_data_t;
  typedef logic [CFG_IDX_W-1:0] cfg_index_t;
  typedef logic signed [1:0] delta_t;

  // Register indexes on the configuration channel.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NOISE_FLOOR = 2'd0,
    CFG_MAX_BLOCK   = 2'd1,
    CFG_MIN_GAP     = 2'd2
  } cfg_reg_t;

  localparam cfg_data_t NOISE_FLOOR_RST = 16'd5;
  localparam cfg_data_t MAX_BLOCK_RST   = 16'd3000;
  localparam cfg_data_t MIN_GAP_RST     = 16'd300;

  // Direction codes.
  localparam delta_t DELTA_NONE = 2'sb00;
  localparam delta_t DELTA_POS  = 2'sb01;
  localparam delta_t DELTA_NEG  = 2'sb11;

endpackage

`default_nettype wire

// ===== rtl/two_beam_direction_counter_top.sv =====
// Two-beam direction counter: tick processing, configuration and output register.
`timescale 1ns / 1ps
`default_nettype none

// Each input transfer is one millisecond tick carrying the sampled levels of
// beams A and B. The block keeps its own millisecond count, timestamps break
// and clear edges of each beam, arms a pass when both beams are blocked with
// a break skew above the noise floor and below the maximum block time, and on
// both beams clearing in the same order emits +1 (A to B) or -1 (B to A),
// subject to the minimum gap since the last counted pass. Every tick yields
// exactly one result transfer (0 when nothing is counted). All work for a tick
// is done combinationally between the input transfer and a single output
// register, so a tick is accepted in every cycle and its result appears in the
// cycle after; the only stall is a full output register that the consumer
// does not take (in_ready follows out_ready). Times wrap modulo
// 2^TIME_WIDTH. Configuration writes are taken in any cycle (cfg_ready is
// always high); indexes beyond the register list are dropped. No clearing
// pass follows reset.
module two_beam_direction_counter_top #(
  parameter int TIME_WIDTH = 32
) (
  input  wire                   clk,
  input  wire                   rst_n,
  // tick channel
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire                   in_beam_a_broken,
  input  wire                   in_beam_b_broken,
  // result channel
  output logic                  out_valid,
  input  wire                   out_ready,
  output tbdc_pkg::delta_t      out_count_delta,
  // configuration channel
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  tbdc_pkg::cfg_index_t  cfg_index,
  input  tbdc_pkg::cfg_data_t   cfg_wdata
);

  import tbdc_pkg::*;

  typedef logic [TIME_WIDTH-1:0] time_t;

  // configuration registers
  cfg_data_t noise_floor_r;
  cfg_data_t max_block_r;
  cfg_data_t min_gap_r;

  // tracking state
  time_t  ms_counter_r,      ms_counter_nxt;
  logic   a_blocked_r,       a_blocked_nxt;
  logic   b_blocked_r,       b_blocked_nxt;
  time_t  a_break_r,         a_break_nxt;
  time_t  b_break_r,         b_break_nxt;
  time_t  a_clear_r,         a_clear_nxt;
  time_t  b_clear_r,         b_clear_nxt;
  logic   pass_armed_r,      pass_armed_nxt;
  delta_t armed_dir_r,       armed_dir_nxt;
  time_t  last_count_r,      last_count_nxt;
  logic   has_counted_r,     has_counted_nxt;

  // output register
  logic   out_valid_r;
  delta_t out_delta_r,       out_delta_nxt;

  logic   in_xfer;
  logic   cfg_xfer;
  time_t  now;
  time_t  brk_diff;
  time_t  later_break;
  time_t  since_last;
  time_t  since_later;
  time_t  noise_ext;
  time_t  max_block_ext;
  time_t  min_gap_ext;
  logic   arm_ok;
  logic   armed_mid;
  delta_t dir_mid;
  delta_t clear_dir;

  // Accept a tick whenever the output register is empty or being drained.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid;

  assign out_valid       = out_valid_r;
  assign out_count_delta = out_delta_r;

  assign noise_ext     = TIME_WIDTH'(noise_floor_r);
  assign max_block_ext = TIME_WIDTH'(max_block_r);
  assign min_gap_ext   = TIME_WIDTH'(min_gap_r);

  // Advance the time base first; every timestamp of this tick uses it.
  assign now = ms_counter_r + TIME_WIDTH'(1);

  // Edge capture: a level that differs from the blocked flag is an edge.
  always_comb begin
    ms_counter_nxt = now;
    a_blocked_nxt  = in_beam_a_broken;
    b_blocked_nxt  = in_beam_b_broken;
    a_break_nxt    = a_break_r;
    a_clear_nxt    = a_clear_r;
    b_break_nxt    = b_break_r;
    b_clear_nxt    = b_clear_r;
    if (in_beam_a_broken != a_blocked_r) begin
      if (in_beam_a_broken) begin
        a_break_nxt = now;
      end else begin
        a_clear_nxt = now;
      end
    end
    if (in_beam_b_broken != b_blocked_r) begin
      if (in_beam_b_broken) begin
        b_break_nxt = now;
      end else begin
        b_clear_nxt = now;
      end
    end
  end

  // Break skew and the later break, both from the freshly captured times.
  assign brk_diff    = (a_break_nxt > b_break_nxt) ? (a_break_nxt - b_break_nxt)
                                                   : (b_break_nxt - a_break_nxt);
  assign later_break = (a_break_nxt > b_break_nxt) ? a_break_nxt : b_break_nxt;
  assign since_last  = now - last_count_r;
  assign since_later = now - later_break;

  // Arm only from idle, with both beams down and a plausible skew.
  assign arm_ok    = a_blocked_nxt && b_blocked_nxt && !pass_armed_r &&
                     (brk_diff > noise_ext) && (brk_diff < max_block_ext);
  assign armed_mid = pass_armed_r || arm_ok;
  assign dir_mid   = arm_ok ? ((a_break_nxt < b_break_nxt) ? DELTA_POS : DELTA_NEG)
                            : armed_dir_r;
  assign clear_dir = (a_clear_nxt < b_clear_nxt) ? DELTA_POS : DELTA_NEG;

  // Pass machine: complete, time out or hold.
  always_comb begin
    pass_armed_nxt  = armed_mid;
    armed_dir_nxt   = dir_mid;
    last_count_nxt  = last_count_r;
    has_counted_nxt = has_counted_r;
    out_delta_nxt   = DELTA_NONE;
    if (armed_mid && !a_blocked_nxt && !b_blocked_nxt) begin
      pass_armed_nxt = 1'b0;
      armed_dir_nxt  = DELTA_NONE;
      // Count only if the clear order matches and the gap has passed.
      if ((clear_dir == dir_mid) && !(has_counted_r && (since_last < min_gap_ext))) begin
        out_delta_nxt   = dir_mid;
        last_count_nxt  = now;
        has_counted_nxt = 1'b1;
      end
    end else if (armed_mid) begin
      // Drop a pass that stays blocked too long after the later break.
      if (since_later > max_block_ext) begin
        pass_armed_nxt = 1'b0;
        armed_dir_nxt  = DELTA_NONE;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_floor_r <= NOISE_FLOOR_RST;
      max_block_r   <= MAX_BLOCK_RST;
      min_gap_r     <= MIN_GAP_RST;
    end else if (cfg_xfer) begin
      case (cfg_index)
        CFG_NOISE_FLOOR: noise_floor_r <= cfg_wdata;
        CFG_MAX_BLOCK:   max_block_r   <= cfg_wdata;
        CFG_MIN_GAP:     min_gap_r     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Tracking state advances once per accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_counter_r  <= '0;
      a_blocked_r   <= 1'b0;
      b_blocked_r   <= 1'b0;
      a_break_r     <= '0;
      b_break_r     <= '0;
      a_clear_r     <= '0;
      b_clear_r     <= '0;
      pass_armed_r  <= 1'b0;
      armed_dir_r   <= DELTA_NONE;
      last_count_r  <= '0;
      has_counted_r <= 1'b0;
    end else if (in_xfer) begin
      ms_counter_r  <= ms_counter_nxt;
      a_blocked_r   <= a_blocked_nxt;
      b_blocked_r   <= b_blocked_nxt;
      a_break_r     <= a_break_nxt;
      b_break_r     <= b_break_nxt;
      a_clear_r     <= a_clear_nxt;
      b_clear_r     <= b_clear_nxt;
      pass_armed_r  <= pass_armed_nxt;
      armed_dir_r   <= armed_dir_nxt;
      last_count_r  <= last_count_nxt;
      has_counted_r <= has_counted_nxt;
    end
  end

  // Output register: load on a tick, clear valid once the result is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_delta_r <= out_delta_nxt;
    end
  end

`include "two_beam_direction_counter_top_macros.svh"

  // The held result never carries the unused code.
  `TBDC_ASSERT_SAME(a_delta_code, clk, rst_n, out_valid_r, out_delta_r != 2'sb10)
  // A counted pass is stamped with the tick that produced it.
  `TBDC_ASSERT_SAME(a_count_stamp, clk, rst_n, out_valid_r && (out_delta_r != DELTA_NONE),
                    has_counted_r && (last_count_r == ms_counter_r))
  // Armed state and stored direction agree.
  `TBDC_ASSERT_SAME(a_armed_dir, clk, rst_n, 1'b1,
                    pass_armed_r == (armed_dir_r != DELTA_NONE))
  // Every accepted tick leaves a result waiting.
  `TBDC_ASSERT_NEXT(a_tick_result, clk, rst_n, in_xfer, out_valid_r)

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the two-beam direction counter.
`timescale 1ns / 1ps

module tb_top;
  import tbdc_pkg::*;

  localparam int TW = 32;
  localparam int N_DIR = 24;
  localparam int N_PHASE = 8;
  localparam int PHASE_TICKS = 225;
  localparam cfg_index_t CFG_IDX_SPARE = 2'd3;

  // Idling styles, one per phase in turn.
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  // One row of the directed table: either a register write or a run of ticks.
  typedef struct packed {
    bit         is_reg;
    cfg_index_t idx;
    cfg_data_t  data;
    bit         a;
    bit         b;
    logic [15:0] reps;
    bit         typed;
    delta_t     delta;
  } step_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_beam_a_broken = 1'b0;
  logic       in_beam_b_broken = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  delta_t     out_count_delta;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cfg_index_t cfg_index = '0;
  cfg_data_t  cfg_wdata = '0;

  // Predicted block state and register copies.
  cfg_data_t     nf_ms = NOISE_FLOOR_RST;
  cfg_data_t     max_blk_ms = MAX_BLOCK_RST;
  cfg_data_t     gap_ms = MIN_GAP_RST;
  logic [TW-1:0] tick_ms = '0;
  bit            a_held = 1'b0;
  bit            b_held = 1'b0;
  logic [TW-1:0] a_brk_ms = '0;
  logic [TW-1:0] b_brk_ms = '0;
  logic [TW-1:0] a_clr_ms = '0;
  logic [TW-1:0] b_clr_ms = '0;
  bit            armed = 1'b0;
  delta_t        armed_dir = DELTA_NONE;
  logic [TW-1:0] last_cnt_ms = '0;
  bit            counted = 1'b0;

  delta_t      pending_deltas [$];
  delta_t      want_delta;
  int unsigned fail_cnt = 0;
  int unsigned ticks_sent = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          cfg_open = 1'b0;
  step_row_t   dir_tab [N_DIR];

  two_beam_direction_counter_top #(
    .TIME_WIDTH(TW)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_beam_a_broken (in_beam_a_broken),
    .in_beam_b_broken (in_beam_b_broken),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_count_delta  (out_count_delta),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Advance the predicted block by one millisecond tick and return its delta.
  function automatic delta_t predict_delta(input bit a, input bit b);
    logic [TW-1:0] skew;
    logic [TW-1:0] later;
    logic [TW-1:0] since;
    delta_t        clr_dir;
    delta_t        res;
    res = DELTA_NONE;
    tick_ms = tick_ms + 1'b1;
    if (a != a_held) begin
      a_held = a;
      if (a) a_brk_ms = tick_ms;
      else a_clr_ms = tick_ms;
    end
    if (b != b_held) begin
      b_held = b;
      if (b) b_brk_ms = tick_ms;
      else b_clr_ms = tick_ms;
    end
    // Arm on both beams blocked with a break skew inside the window.
    if (a_held && b_held && !armed) begin
      skew = (a_brk_ms > b_brk_ms) ? a_brk_ms - b_brk_ms : b_brk_ms - a_brk_ms;
      if (skew > nf_ms && skew < max_blk_ms) begin
        armed_dir = (a_brk_ms < b_brk_ms) ? DELTA_POS : DELTA_NEG;
        armed = 1'b1;
      end
    end
    if (armed && !a_held && !b_held) begin
      // Equal clear times count as B first.
      clr_dir = (a_clr_ms < b_clr_ms) ? DELTA_POS : DELTA_NEG;
      since = tick_ms - last_cnt_ms;
      armed = 1'b0;
      if (clr_dir == armed_dir && !(counted && since < gap_ms)) begin
        res = armed_dir;
        last_cnt_ms = tick_ms;
        counted = 1'b1;
      end
      armed_dir = DELTA_NONE;
    end else if (armed) begin
      later = (a_brk_ms > b_brk_ms) ? a_brk_ms : b_brk_ms;
      since = tick_ms - later;
      if (since > max_blk_ms) begin
        armed = 1'b0;
        armed_dir = DELTA_NONE;
      end
    end
    return res;
  endfunction

  function automatic step_row_t tick_row(input bit a, input bit b, input int reps,
                                         input bit typed, input delta_t delta);
    step_row_t r;
    r = '0;
    r.a = a;
    r.b = b;
    r.reps = reps[15:0];
    r.typed = typed;
    r.delta = delta;
    return r;
  endfunction

  function automatic step_row_t reg_row(input cfg_index_t idx, input cfg_data_t data);
    step_row_t r;
    r = '0;
    r.is_reg = 1'b1;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  // Offer one tick, hold it until the transfer, then log the expected delta.
  task automatic send_tick(input bit a, input bit b, input bit typed = 1'b0,
                           input delta_t typed_delta = DELTA_NONE);
    int idle;
    delta_t d;
    idle = 0;
    while (idle < 40 && $urandom_range(0, 99) < send_idle_pct) idle++;
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beam_a_broken <= a;
    in_beam_b_broken <= b;
    do @(posedge clk); while (!in_ready);
    d = predict_delta(a, b);
    pending_deltas.push_back(typed ? typed_delta : d);
    ticks_sent++;
  endtask

  // Drop valid and hold off until every logged delta has come back.
  task automatic wait_results_done();
    if (in_valid) in_valid <= 1'b0;
    while (pending_deltas.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input cfg_data_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_NOISE_FLOOR: nf_ms = val;
      CFG_MAX_BLOCK:   max_blk_ms = val;
      CFG_MIN_GAP:     gap_ms = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input cfg_data_t nf, input cfg_data_t mb, input cfg_data_t gap);
    wait_results_done();
    write_reg(CFG_NOISE_FLOOR, nf);
    write_reg(CFG_MAX_BLOCK, mb);
    if ($urandom_range(0, 1)) write_reg(CFG_IDX_SPARE, cfg_data_t'($urandom));
    write_reg(CFG_MIN_GAP, gap);
    cfg_valid <= 1'b0;
  endtask

  // One episode: idle, then mostly a pass attempt with random timing,
  // otherwise random beam noise or a single beam held on its own for a random run.
  task automatic run_episode(input int span);
    int kind;
    int order;
    int lead;
    int overlap;
    int trail;
    bit first_a;
    kind = $urandom_range(0, 9);
    first_a = 1'($urandom_range(0, 1));
    repeat ($urandom_range(1, span)) send_tick(1'b0, 1'b0);
    if (kind <= 6) begin
      lead = $urandom_range(0, span);
      overlap = $urandom_range(1, span + 2);
      trail = $urandom_range(1, span);
      order = $urandom_range(0, 2);
      repeat (lead) send_tick(first_a, !first_a);
      repeat (overlap) send_tick(1'b1, 1'b1);
      case (order)
        0: repeat (trail) send_tick(!first_a, first_a);
        1: repeat (trail) send_tick(first_a, !first_a);
        default: ;
      endcase
      send_tick(1'b0, 1'b0);
    end else if (kind <= 8) begin
      repeat ($urandom_range(1, span))
        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else begin
      repeat ($urandom_range(1, 3 * span)) send_tick(first_a, !first_a);
    end
    // Pause now and then until the pipe is empty.
    if ($urandom_range(0, 31) == 0) wait_results_done();
  endtask

  // Receiver: stall at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Compare every result transfer against the oldest logged delta.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_deltas.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("count_delta %0d arrived with nothing pending", out_count_delta);
      end else begin
        want_delta = pending_deltas.pop_front();
        if (out_count_delta !== want_delta) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("count_delta mismatch: expected %0d, got %0d", want_delta,
                     out_count_delta);
        end
      end
    end
  end

  initial begin
    int span;
    int mark;
    cfg_data_t mb;

    // Directed part: reset values first, then a tight window for the corners.
    dir_tab = '{
      tick_row(1'b0, 1'b0, 1, 1'b1, DELTA_NONE),  // nothing after reset
      tick_row(1'b1, 1'b0, 6, 1'b0, DELTA_NONE),  // A breaks first
      tick_row(1'b1, 1'b1, 1, 1'b0, DELTA_NONE),  // skew 6 arms at reset floor
      tick_row(1'b0, 1'b1, 1, 1'b0, DELTA_NONE),
      tick_row(1'b0, 1'b0, 1, 1'b1, DELTA_POS),   // first count, gap skipped
      reg_row(CFG_NOISE_FLOOR, 16'd0),
      reg_row(CFG_MAX_BLOCK, 16'd4),
      reg_row(CFG_MIN_GAP, 16'd4),
      reg_row(CFG_IDX_SPARE, 16'hFFFF),           // dropped by the block
      tick_row(1'b0, 1'b1, 1, 1'b0, DELTA_NONE),
      tick_row(1'b1, 1'b1, 1, 1'b0, DELTA_NONE),  // B first, arms negative
      tick_row(1'b0, 1'b0, 1, 1'b1, DELTA_NONE),  // equal clears but gap too short
      tick_row(1'b0, 1'b1, 1, 1'b0, DELTA_NONE),
      tick_row(1'b1, 1'b1, 1, 1'b0, DELTA_NONE),
      tick_row(1'b0, 1'b0, 1, 1'b1, DELTA_NEG),   // equal clears count as B first
      tick_row(1'b1, 1'b1, 1, 1'b1, DELTA_NONE),  // simultaneous break is noise
      tick_row(1'b0, 1'b0, 1, 1'b0, DELTA_NONE),
      tick_row(1'b1, 1'b0, 1, 1'b0, DELTA_NONE),
      tick_row(1'b1, 1'b1, 6, 1'b0, DELTA_NONE),  // armed pass runs into timeout
      tick_row(1'b0, 1'b0, 1, 1'b1, DELTA_NONE),
      tick_row(1'b1, 1'b0, 1, 1'b0, DELTA_NONE),
      tick_row(1'b1, 1'b1, 1, 1'b0, DELTA_NONE),
      tick_row(1'b1, 1'b0, 1, 1'b0, DELTA_NONE),  // B clears first after A led
      tick_row(1'b0, 1'b0, 1, 1'b1, DELTA_NONE)   // order mismatch
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      if (dir_tab[i].is_reg) begin
        // Registers change only with nothing in flight.
        if (!cfg_open) wait_results_done();
        write_reg(dir_tab[i].idx, dir_tab[i].data);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) begin
          cfg_valid <= 1'b0;
          cfg_open = 1'b0;
        end
        repeat (dir_tab[i].reps)
          send_tick(dir_tab[i].a, dir_tab[i].b, dir_tab[i].typed, dir_tab[i].delta);
      end
    end

    // Random phases: each one sets the registers, then runs episodes.
    for (int ph = 0; ph < N_PHASE; ph++) begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
      wait_results_done();
      case (ph)
        4: begin
          set_config(16'd0, 16'hFFFF, 16'd0);
          span = 12;
        end
        5: begin
          set_config(16'hFFFF, cfg_data_t'($urandom_range(4, 24)),
                     cfg_data_t'($urandom_range(0, 30)));
          span = 16;
        end
        6: begin
          set_config(cfg_data_t'($urandom_range(0, 3)), 16'd0, 16'hFFFF);
          span = 8;
        end
        7: begin
          set_config(NOISE_FLOOR_RST, MAX_BLOCK_RST, MIN_GAP_RST);
          span = 24;
        end
        default: begin
          mb = cfg_data_t'($urandom_range(4, 24));
          set_config(cfg_data_t'($urandom_range(0, 3)), mb,
                     cfg_data_t'($urandom_range(0, 30)));
          span = int'(mb) + 4;
        end
      endcase
      case (ph % 4)
        IDLE_SEND: send_idle_pct = 75;
        IDLE_RECV: recv_stall_pct = 75;
        IDLE_BOTH: begin
          send_idle_pct = 17;
          recv_stall_pct = 17;
        end
        default: ;
      endcase
      mark = ticks_sent;
      while (ticks_sent - mark < PHASE_TICKS) run_episode(span);
    end

    // Drain, then let a late stray result show up before the verdict.
    wait_results_done();
    repeat (4) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("PASS two_beam_direction_counter_top");
    end else begin
      $display("FAIL two_beam_direction_counter_top");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL two_beam_direction_counter_top");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tbdc_pkg.sv
rtl/two_beam_direction_counter_top.sv
sim/tb_top.sv
